### sv/bld_pkg.sv
// Shared constants and types for the BFS level-distance block.
`timescale 1ns / 1ps
`default_nettype none

package bld_pkg;

  // command codes
  localparam logic [1:0] CMD_ROW  = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 14;
  localparam int NODE_W  = 10;
  localparam int DIST_W  = 10;
  localparam int CFG_W   = 11;
  localparam int OFF_W   = 14;
  localparam int TGT_W   = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              reached;
    logic              error;
  } result_t;

endpackage

`default_nettype wire

### sv/bld_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/bfs_level_distances_top.sv
// Top level: BFS over a CSR graph, with table loads, search sequencer and level reads.
//
// Commands enter on start/cmd/index/value and are taken when start is high and
// busy is low. Row-offset and edge-target writes give no result; busy stays
// low. A read gives its result after the S_READ state, in which busy is high.
// A run whose source is not below the node count gives an error result on the
// next cycle. A good run first sweeps the level memory, marks the source, then
// walks the frontier FIFO: each node taken from the FIFO passes S_POP, S_POP1
// and S_POP2, then its row offsets are read in S_ROW0 to S_ROW2; each edge takes
// S_EDGE and S_TGT, and an edge whose target is below the node count also S_CHK.
// The single read port of each memory sets this sequence. Busy is held for the
// whole search and the result (source, distance 0) is given at the end.
// Results appear for one cycle with done high; the receiver cannot stall them.
// Users write node_count via cfg_write/cfg_data only while idle (not enforced).
// After rst the level memory is swept to unreached: busy is high for the whole
// sweep, during which no command is taken.
`timescale 1ns / 1ps
`default_nettype none

module bfs_level_distances_top #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [bld_pkg::CMD_W-1:0]    cmd,
  input  wire logic [bld_pkg::INDEX_W-1:0]  index,
  input  wire logic [bld_pkg::VALUE_W-1:0]  value,
  input  wire logic                         cfg_write,
  input  wire logic [bld_pkg::CFG_W-1:0]    cfg_data,
  output logic                              done,
  output logic [bld_pkg::NODE_W-1:0]        node,
  output logic [bld_pkg::DIST_W-1:0]        distance,
  output logic                              reached,
  output logic                              error
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int EW    = $clog2(MAX_EDGES);
  localparam int RW    = $clog2(MAX_NODES + 1);
  localparam int CW0   = $clog2(MAX_NODES + 1);
  localparam int CNT_W = (CW0 > bld_pkg::CFG_W) ? CW0 : bld_pkg::CFG_W;
  localparam int LW    = NW + 1;  // valid bit over level

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_SRC   = 4'd2;
  localparam logic [3:0] S_ROW0  = 4'd3;
  localparam logic [3:0] S_ROW1  = 4'd4;
  localparam logic [3:0] S_ROW2  = 4'd5;
  localparam logic [3:0] S_EDGE  = 4'd6;
  localparam logic [3:0] S_TGT   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_POP   = 4'd9;
  localparam logic [3:0] S_POP1  = 4'd10;
  localparam logic [3:0] S_POP2  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_READ  = 4'd13;

  logic [3:0]                  state;
  logic                        run_clear;
  logic [NW-1:0]               clr_addr;
  logic [bld_pkg::CFG_W-1:0]   node_count;
  logic [CNT_W-1:0]            count;
  logic [NW-1:0]               src;
  logic [bld_pkg::NODE_W-1:0]  src_out;
  logic [NW-1:0]               cur;
  logic [NW-1:0]               lvl_cur;
  logic [NW-1:0]               tgt;
  logic [bld_pkg::OFF_W-1:0]   ptr;
  logic [bld_pkg::OFF_W-1:0]   hi;
  logic [NW-1:0]               head;
  logic [NW-1:0]               tail;
  logic                        rd_ok;
  logic [bld_pkg::NODE_W-1:0]  rd_node;
  bld_pkg::result_t            res;

  logic accept;
  logic clr_last;
  logic tgt_skip;

  // memory ports
  logic                       row_we;
  logic [RW-1:0]              row_raddr;
  logic [bld_pkg::OFF_W-1:0]  row_rdata;
  logic                       edge_we;
  logic [EW-1:0]              edge_raddr;
  logic [bld_pkg::TGT_W-1:0]  edge_rdata;
  logic                       lvl_we;
  logic [NW-1:0]              lvl_waddr;
  logic [LW-1:0]              lvl_wdata;
  logic [NW-1:0]              lvl_raddr;
  logic [LW-1:0]              lvl_rdata;
  logic                       fifo_we;
  logic [NW-1:0]              fifo_rdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign count    = (32'(node_count) < MAX_NODES) ? CNT_W'(node_count) : CNT_W'(MAX_NODES);
  assign clr_last = (clr_addr == NW'(MAX_NODES - 1));
  assign tgt_skip = (32'(edge_rdata) >= 32'(count));

  assign node     = res.node;
  assign distance = res.distance;
  assign reached  = res.reached;
  assign error    = res.error;

  always_comb begin
    row_we    = accept && (cmd == bld_pkg::CMD_ROW) && (32'(index) <= MAX_NODES);
    edge_we   = accept && (cmd == bld_pkg::CMD_EDGE) && (32'(index) < MAX_EDGES);
    row_raddr = (state == S_ROW1) ? (RW'(cur) + RW'(1)) : RW'(cur);
    edge_raddr = EW'(ptr);

    unique case (state)
      S_IDLE:  lvl_raddr = NW'(index);
      S_TGT:   lvl_raddr = NW'(edge_rdata);
      S_POP1:  lvl_raddr = fifo_rdata;
      default: lvl_raddr = cur;
    endcase

    lvl_we    = 1'b0;
    lvl_waddr = clr_addr;
    lvl_wdata = '0;
    fifo_we   = 1'b0;
    unique case (state)
      S_CLEAR: lvl_we = 1'b1;
      S_SRC: begin
        lvl_we    = 1'b1;
        lvl_waddr = src;
        lvl_wdata = {1'b1, {NW{1'b0}}};
      end
      S_CHK: begin
        // first sighting of this target
        if (!lvl_rdata[NW]) begin
          lvl_we    = 1'b1;
          lvl_waddr = tgt;
          lvl_wdata = {1'b1, lvl_cur + NW'(1)};
          fifo_we   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  bld_ram #(.WIDTH(bld_pkg::OFF_W), .DEPTH(MAX_NODES + 1)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RW'(index)),
    .wdata (value),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  bld_ram #(.WIDTH(bld_pkg::TGT_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EW'(index)),
    .wdata (value[bld_pkg::TGT_W-1:0]),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  bld_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  bld_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (tgt),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      run_clear  <= 1'b0;
      clr_addr   <= '0;
      node_count <= bld_pkg::CFG_RESET;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              bld_pkg::CMD_RUN: begin
                if ({18'd0, value} >= 32'(count)) begin
                  done         <= 1'b1;
                  res.node     <= '0;
                  res.distance <= '0;
                  res.reached  <= 1'b0;
                  res.error    <= 1'b1;
                end else begin
                  src       <= NW'(value);
                  src_out   <= value[bld_pkg::NODE_W-1:0];
                  clr_addr  <= '0;
                  run_clear <= 1'b1;
                  state     <= S_CLEAR;
                end
              end
              bld_pkg::CMD_READ: begin
                rd_ok   <= (32'(index) < MAX_NODES);
                rd_node <= index[bld_pkg::NODE_W-1:0];
                state   <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_last) begin
            state <= run_clear ? S_SRC : S_IDLE;
          end
        end
        S_SRC: begin
          cur     <= src;
          lvl_cur <= '0;
          head    <= '0;
          tail    <= '0;
          state   <= S_ROW0;
        end
        S_ROW0: state <= S_ROW1;
        S_ROW1: begin
          ptr   <= row_rdata;
          state <= S_ROW2;
        end
        S_ROW2: begin
          // edge range end is clamped to the table size
          hi    <= (32'(row_rdata) > MAX_EDGES) ? bld_pkg::OFF_W'(MAX_EDGES) : row_rdata;
          state <= S_EDGE;
        end
        S_EDGE: begin
          state <= (ptr >= hi) ? S_POP : S_TGT;
        end
        S_TGT: begin
          tgt <= NW'(edge_rdata);
          if (tgt_skip) begin
            ptr   <= ptr + 1'b1;
            state <= S_EDGE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!lvl_rdata[NW]) begin
            tail <= tail + NW'(1);
          end
          ptr   <= ptr + 1'b1;
          state <= S_EDGE;
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_FIN;
          end else begin
            head  <= head + NW'(1);
            state <= S_POP1;
          end
        end
        S_POP1: begin
          cur   <= fifo_rdata;
          state <= S_POP2;
        end
        S_POP2: begin
          lvl_cur <= lvl_rdata[NW-1:0];
          state   <= S_ROW0;
        end
        S_FIN: begin
          done         <= 1'b1;
          res.node     <= src_out;
          res.distance <= '0;
          res.reached  <= 1'b1;
          res.error    <= 1'b0;
          state        <= S_IDLE;
        end
        S_READ: begin
          done         <= 1'b1;
          res.node     <= rd_node;
          res.distance <= (rd_ok && lvl_rdata[NW]) ? bld_pkg::DIST_W'(lvl_rdata[NW-1:0]) : '0;
          res.reached  <= rd_ok && lvl_rdata[NW];
          res.error    <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/bfs_level_distances_top_tb.sv
// Self-checking testbench for the CSR breadth-first search block: directed and random commands.
`timescale 1ns / 1ps

module bfs_level_distances_top_tb;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_EDGES   = 8192;
  localparam int RAND_BEATS  = 400;
  localparam int CHAIN_NODES = 160;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 8;
  localparam int VALUE_TOP   = (1 << bld_pkg::VALUE_W) - 1;
  localparam int INDEX_TOP   = (1 << bld_pkg::INDEX_W) - 1;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [bld_pkg::CMD_W-1:0]   cmd = bld_pkg::CMD_ROW;
  logic [bld_pkg::INDEX_W-1:0] index = '0;
  logic [bld_pkg::VALUE_W-1:0] value = '0;
  logic                        cfg_write = 1'b0;
  logic [bld_pkg::CFG_W-1:0]   cfg_data = bld_pkg::CFG_RESET;
  logic                        done;
  logic [bld_pkg::NODE_W-1:0]  node;
  logic [bld_pkg::DIST_W-1:0]  distance;
  logic                        reached;
  logic                        error;

  bfs_level_distances_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .index     (index),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .done      (done),
    .node      (node),
    .distance  (distance),
    .reached   (reached),
    .error     (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's tables and levels
  int      row_table  [0:MAX_NODES];
  bit      row_known  [0:MAX_NODES];
  int      edge_table [0:MAX_EDGES-1];
  bit      edge_known [0:MAX_EDGES-1];
  int      level_of   [0:MAX_NODES-1];
  bit      level_set  [0:MAX_NODES-1];
  int      trial_level[0:MAX_NODES-1];
  bit      trial_set  [0:MAX_NODES-1];
  int      frontier   [0:MAX_NODES-1];
  int      node_limit = bld_pkg::CFG_RESET;

  bld_pkg::result_t pending_results[$];
  int      beats_sent = 0;
  int      results_seen = 0;
  int      runs_good = 0;
  int      runs_bad = 0;
  int      reads_hit = 0;
  int      fail_count = 0;
  int      cycles = 0;
  int      burst_left = 0;
  bit      start_high = 0;

  function automatic int active_nodes();
    return node_limit < MAX_NODES ? node_limit : MAX_NODES;
  endfunction

  // Level walk into the trial arrays; returns 0 if any table entry read was never loaded.
  function automatic bit trace_levels(int src);
    int head, tail, cur, lo, hi, tgt, cnt;
    bit clean;
    head = 0;
    tail = 0;
    cur = src;
    clean = 1;
    cnt = active_nodes();
    for (int n = 0; n < MAX_NODES; n++) begin
      trial_set[n] = 0;
      trial_level[n] = 0;
    end
    trial_set[src] = 1;
    while (1) begin
      if (!row_known[cur] || !row_known[cur+1]) clean = 0;
      lo = row_table[cur];
      hi = row_table[cur+1];
      if (hi > MAX_EDGES) hi = MAX_EDGES;
      for (int e = lo; e < hi; e++) begin
        if (!edge_known[e]) clean = 0;
        tgt = edge_table[e];
        if (tgt < cnt && !trial_set[tgt]) begin
          trial_set[tgt] = 1;
          trial_level[tgt] = trial_level[cur] + 1;
          if (tail < MAX_NODES) begin
            frontier[tail] = tgt;
            tail++;
          end
        end
      end
      if (head >= tail) break;
      cur = frontier[head];
      head++;
    end
    return clean;
  endfunction

  // Update the shadow for one accepted beat and queue what it should produce.
  function automatic void apply_command(logic [bld_pkg::CMD_W-1:0] c, int idx, int val);
    bld_pkg::result_t r;
    bit               ok;
    case (c)
      bld_pkg::CMD_ROW: begin
        if (idx <= MAX_NODES) begin
          row_table[idx] = val;
          row_known[idx] = 1;
        end
      end
      bld_pkg::CMD_EDGE: begin
        if (idx < MAX_EDGES) begin
          edge_table[idx] = val % MAX_NODES;
          edge_known[idx] = 1;
        end
      end
      bld_pkg::CMD_RUN: begin
        if (val >= active_nodes()) begin
          r.node = '0;
          r.distance = '0;
          r.reached = 1'b0;
          r.error = 1'b1;
          runs_bad++;
        end else begin
          void'(trace_levels(val));
          level_of = trial_level;
          level_set = trial_set;
          r.node = bld_pkg::NODE_W'(val);
          r.distance = '0;
          r.reached = 1'b1;
          r.error = 1'b0;
          runs_good++;
        end
        pending_results.push_back(r);
      end
      default: begin
        ok = (idx < MAX_NODES) && level_set[idx % MAX_NODES];
        r.node = bld_pkg::NODE_W'(idx);
        r.distance = ok ? bld_pkg::DIST_W'(level_of[idx % MAX_NODES]) : '0;
        r.reached = ok;
        r.error = 1'b0;
        if (ok) reads_hit++;
        pending_results.push_back(r);
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the rising edge that took the beat.
  task automatic send_beat(input logic [bld_pkg::CMD_W-1:0] c, input int idx, input int val);
    bit taken;
    start <= 1'b1;
    cmd <= c;
    index <= bld_pkg::INDEX_W'(idx);
    value <= bld_pkg::VALUE_W'(val);
    start_high = 1;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    apply_command(c, idx, val);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      start_high = 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      // mostly short bursts, now and then a long one with no idling
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8);
    end
  endtask

  // A source whose search would touch unloaded table entries is swapped for a rejected one.
  task automatic send_run(input int src);
    int s;
    s = src;
    if (s < active_nodes() && !trace_levels(s)) s = $urandom_range(VALUE_TOP, active_nodes());
    send_beat(bld_pkg::CMD_RUN, $urandom_range(INDEX_TOP), s);
  endtask

  task automatic wait_idle();
    if (start_high) begin
      start <= 1'b0;
      start_high = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    do @(negedge clk); while (busy !== 1'b0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_node_count(input int n);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= bld_pkg::CFG_W'(n);
    @(posedge clk);
    cfg_write <= 1'b0;
    node_limit = n;
  endtask

  always @(negedge clk) begin : check_results
    bld_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: node %0d", node);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, node);
          fail_count++;
        end
        if (distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance);
          fail_count++;
        end
        if (reached !== want.reached) begin
          $error("reached: expected %0b, got %0b", want.reached, reached);
          fail_count++;
        end
        if (error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout: %0d results still outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Four-node graph whose edges sit at the very top of the edge table.
  task automatic test_directed_graph();
    set_node_count(4);
    send_beat(bld_pkg::CMD_READ, 0, 0);              // nothing searched yet
    send_beat(bld_pkg::CMD_READ, INDEX_TOP, 0);
    send_beat(bld_pkg::CMD_ROW, MAX_NODES + 1, 3);   // slot past the table, dropped
    send_beat(bld_pkg::CMD_ROW, INDEX_TOP, VALUE_TOP);
    send_beat(bld_pkg::CMD_ROW, 0, MAX_EDGES - 4);
    send_beat(bld_pkg::CMD_ROW, 1, MAX_EDGES - 1);
    send_beat(bld_pkg::CMD_ROW, 2, VALUE_TOP);       // node 1 range clamps at table end
    send_beat(bld_pkg::CMD_ROW, 3, 5);               // node 2 range reversed
    send_beat(bld_pkg::CMD_ROW, 4, 5);               // node 3 range empty
    send_beat(bld_pkg::CMD_EDGE, MAX_EDGES - 4, (15 << 10) | 1);   // upper bits dropped
    send_beat(bld_pkg::CMD_EDGE, MAX_EDGES - 3, MAX_NODES - 1);    // beyond node count
    send_beat(bld_pkg::CMD_EDGE, MAX_EDGES - 2, 0);
    send_beat(bld_pkg::CMD_EDGE, MAX_EDGES - 1, 3);
    send_run(0);
    for (int n = 0; n < 4; n++) send_beat(bld_pkg::CMD_READ, n, 0);
    send_run(4);
    send_run(VALUE_TOP);
    send_beat(bld_pkg::CMD_READ, 3, 0);              // levels survive a rejected run
    send_beat(bld_pkg::CMD_READ, MAX_NODES, 0);
  endtask

  task automatic test_count_extremes();
    set_node_count(1);
    send_run(0);
    send_beat(bld_pkg::CMD_READ, 0, 0);
    send_beat(bld_pkg::CMD_READ, 1, 0);
    send_run(1);
    set_node_count(MAX_NODES);
    send_run(3);
    send_beat(bld_pkg::CMD_READ, 3, 0);
  endtask

  // Chain of CHAIN_NODES nodes: many levels and a long walk of the frontier.
  task automatic test_long_chain();
    set_node_count(MAX_NODES);
    for (int n = 0; n <= CHAIN_NODES; n++) begin
      send_beat(bld_pkg::CMD_ROW, n, (n < CHAIN_NODES) ? n : CHAIN_NODES - 1);
      if (n < CHAIN_NODES - 1) send_beat(bld_pkg::CMD_EDGE, n, n + 1);
    end
    send_run(0);
    send_beat(bld_pkg::CMD_READ, CHAIN_NODES - 1, 0);
    send_beat(bld_pkg::CMD_READ, CHAIN_NODES / 2, 0);
    send_beat(bld_pkg::CMD_READ, CHAIN_NODES / 3, 0);
    send_run(CHAIN_NODES - 1);
    send_beat(bld_pkg::CMD_READ, CHAIN_NODES - 2, 0);
    send_beat(bld_pkg::CMD_READ, CHAIN_NODES - 1, 0);
  endtask

  task automatic test_random_graphs();
    int stop_at, n, base, ptr, deg, tgt, runs, reads, src, idx;
    stop_at = beats_sent + RAND_BEATS;
    while (beats_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: set_node_count(1);
          1: set_node_count(MAX_NODES);
          2: set_node_count($urandom_range(64, 2));
          default: set_node_count($urandom_range(MAX_NODES, 1));
        endcase
      end
      n = ($urandom_range(14) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 2);
      base = ($urandom_range(5) == 0) ? MAX_EDGES - 3 * n : $urandom_range(MAX_EDGES - 3 * n);
      ptr = base;
      for (int u = 0; u <= n; u++) begin
        // an odd row offset gives reversed, empty or clamped ranges
        send_beat(bld_pkg::CMD_ROW, u,
                  ($urandom_range(11) == 0) ? $urandom_range(VALUE_TOP) : ptr);
        if (u < n) begin
          deg = $urandom_range(3);
          for (int d = 0; d < deg; d++) begin
            case ($urandom_range(7))
              0: tgt = $urandom_range(VALUE_TOP);
              1: tgt = ($urandom_range(15) << 10) | $urandom_range(n - 1);
              default: tgt = $urandom_range(n - 1);
            endcase
            send_beat(bld_pkg::CMD_EDGE, ptr, tgt);
            ptr++;
          end
        end
        if ($urandom_range(19) == 0) begin
          case ($urandom_range(2))
            0: send_beat(bld_pkg::CMD_ROW, $urandom_range(INDEX_TOP, MAX_NODES + 1),
                         $urandom_range(VALUE_TOP));
            1: send_beat(bld_pkg::CMD_READ, $urandom_range(INDEX_TOP),
                         $urandom_range(VALUE_TOP));
            default: send_run($urandom_range(VALUE_TOP));
          endcase
        end
      end
      runs = $urandom_range(4, 1);
      for (int r = 0; r < runs; r++) begin
        src = ($urandom_range(5) == 0) ? $urandom_range(VALUE_TOP) : $urandom_range(n - 1);
        send_run(src);
        reads = $urandom_range(8, 2);
        for (int k = 0; k < reads; k++) begin
          idx = ($urandom_range(7) == 0) ? $urandom_range(INDEX_TOP) : $urandom_range(n - 1);
          send_beat(bld_pkg::CMD_READ, idx, $urandom_range(VALUE_TOP));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_graph();
    test_count_extremes();
    test_long_chain();
    test_random_graphs();
    wait_idle();
    $display("Sent %0d beats, checked %0d results: %0d searches, %0d rejected sources,",
             beats_sent, results_seen, runs_good, runs_bad);
    $display("%0d reads of reached nodes, node counts from 1 to %0d.", reads_hit, MAX_NODES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bld_pkg.sv
sv/bld_ram.sv
sv/bfs_level_distances_top.sv
verif/bfs_level_distances_top_tb.sv
